// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the console RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");

// Condition that must never hold outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== hdl/tcw_pkg.sv =====
// Shared types and codes for the text console writer.
// No dependencies; imported by tcw_cursor and text_console_writer.
package tcw_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // control bytes and blank
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_BLANK = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'd15;

    // register index decoded from paddr[2]
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef struct packed {
        logic       step;   // apply a put byte
        logic       home;   // cursor to row 0, column 0
        logic [7:0] code;
    } t_cur_ctl;

    typedef struct packed {
        logic scroll;       // this step moves past the bottom row
        logic printable;    // this step stores a character at the cursor
    } t_cur_stat;

    function automatic logic [15:0] blank_cell(input logic [7:0] attr);
        return {attr, CHR_BLANK};
    endfunction

endpackage

// ===== hdl/text_console_writer.sv =====
// Text console writer: top level with APB register, sweep sequencer and cell RAM.
// Depends on tcw_pkg, tcw_ram, tcw_cursor and assert_macros.svh.
//
// A COLUMNS x ROWS console of 16-bit cells (attribute high byte, character low
// byte) held in one single-port-write RAM with a registered read.
// After reset the block walks the RAM once to write blanks with attribute 15
// and takes no item until that ends; text_attribute may be written meanwhile.
// A put that does not scroll, a read and an unused action go through S_DONE or
// S_READ to the output register. A clear blanks every cell with text_attribute
// in S_FILL. A put that moves past the bottom row copies every line up through
// the RAM one cell a cycle and blanks the last line. The single RAM write port
// makes these sweeps go one cell at a time.
// A new item is accepted while an earlier result still waits on a stalled
// output.
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_address,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_location,
    output logic [15:0] o_cell_word
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int WIDE      = ((AW > 11) ? AW : 11) + 1;
    localparam int LAST      = CELLS - 1;
    localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_FILL, S_SCROLL, S_BOTTOM, S_READ, S_DONE
    } t_state;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic           r_pend, n_pend;     // copy beat waiting on read data
    logic [AW-1:0]  r_waddr, n_waddr;
    logic           r_rd_ok, n_rd_ok;
    logic           r_out_valid, n_out_valid;
    logic [10:0]    r_out_loc, n_out_loc;
    logic [15:0]    r_out_word, n_out_word;
    logic [7:0]     r_attr;

    logic           w_in_accept;
    logic           w_slot_free;
    logic           w_load;
    logic [WIDE-1:0] w_addr_ext;
    logic           w_addr_ok;

    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [15:0]    w_wdata;
    logic           w_re;
    logic [AW-1:0]  w_raddr;
    logic [15:0]    w_rdata;

    t_cur_ctl       w_cur_ctl;
    t_cur_stat      w_cur_stat;
    logic [AW-1:0]  w_cur_addr;
    logic [10:0]    w_cur_loc;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, r_attr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_ATTR) begin
            r_attr <= pwdata[7:0];
        end
    end

    // ---------------- handshake ----------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_addr_ext = WIDE'(i_cell_address);
    assign w_addr_ok  = (w_addr_ext < WIDE'(CELLS));

    assign w_cur_ctl.step = w_in_accept && (i_action == ACT_PUT);
    assign w_cur_ctl.home = w_in_accept && (i_action == ACT_CLEAR);
    assign w_cur_ctl.code = i_char_code;

    tcw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_cur_ctl),
        .o_stat      (w_cur_stat),
        .o_cell_addr (w_cur_addr),
        .o_location  (w_cur_loc)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_waddr     = r_waddr;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_loc   = r_out_loc;
        n_out_word  = r_out_word;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = blank_cell(r_attr);
        w_re        = 1'b0;
        w_raddr     = w_addr_ext[AW-1:0];

        // copied cell lands in the cycle after its read
        if (r_pend) begin
            w_we    = 1'b1;
            w_waddr = r_waddr;
            w_wdata = w_rdata;
        end

        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = blank_cell(ATTR_RESET);
                if (r_ptr == AW'(LAST)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_in_accept) begin
                    unique case (i_action)
                        ACT_PUT: begin
                            if (w_cur_stat.printable) begin
                                w_we    = 1'b1;
                                w_waddr = w_cur_addr;
                                w_wdata = {r_attr, i_char_code};
                            end
                            n_ptr   = '0;
                            n_state = w_cur_stat.scroll ? S_SCROLL : S_DONE;
                        end
                        ACT_CLEAR: begin
                            n_ptr   = '0;
                            n_state = S_FILL;
                        end
                        ACT_READ: begin
                            w_re    = 1'b1;
                            n_rd_ok = w_addr_ok;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we = 1'b1;
                if (r_ptr == AW'(LAST)) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_SCROLL: begin
                w_re    = 1'b1;
                w_raddr = r_ptr + AW'(COLUMNS);
                n_pend  = 1'b1;
                n_waddr = r_ptr;
                if (r_ptr == AW'(COPY_LAST)) begin
                    n_state = S_BOTTOM;
                end
                n_ptr = r_ptr + AW'(1);
            end
            S_BOTTOM: begin
                if (!r_pend) begin
                    w_we = 1'b1;
                    if (r_ptr == AW'(LAST)) begin
                        n_state = S_DONE;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end
            S_READ: begin
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_loc   = w_cur_loc;
                    n_out_word  = r_rd_ok ? w_rdata : 16'd0;
                    n_state     = S_IDLE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_loc   = w_cur_loc;
                    n_out_word  = 16'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_waddr    <= n_waddr;
        r_rd_ok    <= n_rd_ok;
        r_out_loc  <= n_out_loc;
        r_out_word <= n_out_word;
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_location = r_out_loc;
    assign o_cell_word       = r_out_word;

    // line copy writes always trail the read stream
    `ASSERT_AT(a_copy_order, i_clk, i_rst_n, (r_state == S_SCROLL && r_pend) |-> (r_waddr < w_raddr))
    `ASSERT_NEVER(a_load_with_pend, i_clk, i_rst_n, w_load && r_pend)
    `ASSERT_AT(a_read_next, i_clk, i_rst_n, (w_in_accept && i_action == ACT_READ) |=> (r_state == S_READ))

endmodule

// ===== hdl/tcw_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcw_cursor.sv =====
// Cursor registers and put-byte decode: column, row, tab phase, wrap and scroll.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_cursor import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    parameter int TAB_WIDTH = 8,
    localparam int AW = $clog2(ROWS * COLUMNS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cur_ctl      i_ctl,
    output t_cur_stat     o_stat,
    output logic [AW-1:0] o_cell_addr,
    output logic [10:0]   o_location
);

    localparam int CLW = $clog2(COLUMNS);
    localparam int NCW = $clog2(COLUMNS + TAB_WIDTH);
    localparam int RW  = $clog2(ROWS);
    localparam int RW1 = RW + 1;
    localparam int PW  = $clog2(TAB_WIDTH);
    localparam int LW  = (AW > 11) ? AW : 11;

    logic [CLW-1:0] r_col;
    logic [RW-1:0]  r_row;
    logic [PW-1:0]  r_phase;   // column modulo tab width

    logic [NCW-1:0] n_col;
    logic [RW1-1:0] n_row;
    logic [PW-1:0]  n_phase;
    logic           w_row_inc;
    logic           w_print;
    logic           w_scroll;
    logic [AW-1:0]  w_lin;
    logic [LW-1:0]  w_lin_wide;

    always_comb begin
        n_col     = NCW'(r_col);
        n_phase   = r_phase;
        w_row_inc = 1'b0;
        w_print   = 1'b0;
        unique case (i_ctl.code)
            CHR_BS: begin
                if (r_col != '0) begin
                    n_col   = NCW'(r_col) - NCW'(1);
                    n_phase = (r_phase == '0) ? PW'(TAB_WIDTH - 1) : r_phase - PW'(1);
                end
            end
            CHR_TAB: begin
                n_col   = NCW'(r_col) + NCW'(TAB_WIDTH) - NCW'(r_phase);
                n_phase = '0;
            end
            CHR_CR: begin
                n_col   = '0;
                n_phase = '0;
            end
            CHR_LF: begin
                n_col     = '0;
                n_phase   = '0;
                w_row_inc = 1'b1;
            end
            default: begin
                // 0x20..0x7F print; everything else leaves the cursor alone
                if (i_ctl.code >= CHR_BLANK && !i_ctl.code[7]) begin
                    w_print = 1'b1;
                    n_col   = NCW'(r_col) + NCW'(1);
                    n_phase = (r_phase == PW'(TAB_WIDTH - 1)) ? '0 : r_phase + PW'(1);
                end
            end
        endcase
        if (n_col >= NCW'(COLUMNS)) begin
            n_col     = '0;
            n_phase   = '0;
            w_row_inc = 1'b1;
        end
        n_row    = RW1'(r_row) + RW1'(w_row_inc);
        w_scroll = (n_row >= RW1'(ROWS));
        if (w_scroll) begin
            n_row = RW1'(ROWS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.home) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_ctl.step) begin
            r_col   <= n_col[CLW-1:0];
            r_row   <= n_row[RW-1:0];
            r_phase <= n_phase;
        end
    end

    assign o_stat.scroll    = i_ctl.step & w_scroll;
    assign o_stat.printable = i_ctl.step & w_print;

    assign w_lin       = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign w_lin_wide  = LW'(w_lin);
    assign o_cell_addr = w_lin;
    assign o_location  = w_lin_wide[10:0];

    `ASSERT_AT(a_col_bound, i_clk, i_rst_n, NCW'(r_col) < NCW'(COLUMNS))
    `ASSERT_AT(a_row_bound, i_clk, i_rst_n, RW1'(r_row) < RW1'(ROWS))

endmodule
